@@ design/abf_pkg.sv @@
package abf_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int YW     = $clog2(MAX_HEIGHT);
	localparam int FW     = $clog2(MAX_WIDTH + 1);
	localparam int FH     = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = $clog2(DEPTH);
	localparam int PW     = YW + FW;
	localparam int CFG_W  = 9;
	localparam int PIX_W  = 24;
	localparam int CW     = 17;

	localparam int FW_RESET = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int FH_RESET = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FILL  = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] x_left;
		logic signed [15:0] y_top;
		logic signed [15:0] x_right;
		logic signed [15:0] y_bottom;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
	} cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_data;
		logic             status;
	} res_t;

	typedef struct packed {
		logic          re;
		logic [AW-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic             we;
		logic [AW-1:0]    addr;
		logic [PIX_W-1:0] data;
	} wr_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} color_t;

	function automatic logic [AW-1:0] pix_addr(input logic [YW-1:0] row,
		input logic [XW-1:0] col, input logic [FW-1:0] stride);
		logic [PW-1:0] p;
		p = PW'(row) * PW'(stride) + PW'(col);
		return p[AW-1:0];
	endfunction

endpackage

@@ design/alpha_blend_rect_fill.sv @@
// Rectangle fill engine with alpha blending over a 256 x 256 store of 24-bit
// 0xRRGGBB pixels. After reset the store is swept to black, one pixel per
// cycle; commands are held off during that sweep, while the frame size
// registers can be written at any time the engine is idle. A command is taken
// only when the engine is idle and gives exactly one result transfer. A pixel
// read passes through the decode, pixel, read-data and done states; a pixel
// write through decode, pixel and done; a rejected access from decode to done.
// A fill covers its clipped area at one pixel per cycle, set by the single
// read port of the frame store that feeds the read, blend and write-back
// pipeline, and then waits in a drain state until that pipeline is empty.
module alpha_blend_rect_fill (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [abf_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  abf_pkg::cmd_t              cmd,
	output logic                       res_valid,
	input  logic                       res_ready,
	output abf_pkg::res_t              res
);
	import abf_pkg::*;

	logic [FW-1:0]    fw_q;
	logic [FH-1:0]    fh_q;
	logic [FW-1:0]    fw_new;
	logic [FH-1:0]    fh_new;
	rd_req_t          rd;
	wr_req_t          ctrl_wr, blend_wr, wr;
	color_t           color;
	logic             blend_issue, blend_busy;
	logic [PIX_W-1:0] rdata;

	always_comb begin
		if (cfg_data == '0) begin
			fw_new = FW'(1);
			fh_new = FH'(1);
		end else begin
			fw_new = (32'(cfg_data) > 32'(MAX_WIDTH)) ? FW'(MAX_WIDTH) : FW'(cfg_data);
			fh_new = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? FH'(MAX_HEIGHT) : FH'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW'(FW_RESET);
			fh_q <= FH'(FH_RESET);
		end else if (cfg_we) begin
			if (cfg_index == CFG_FRAME_WIDTH) begin
				fw_q <= fw_new;
			end
			if (cfg_index == CFG_FRAME_HEIGHT) begin
				fh_q <= fh_new;
			end
		end
	end

	abf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fw          (fw_q),
		.fh          (fh_q),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.rd          (rd),
		.wr          (ctrl_wr),
		.blend_issue (blend_issue),
		.color       (color),
		.blend_busy  (blend_busy),
		.rdata       (rdata)
	);

	abf_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (blend_issue),
		.issue_addr (rd.addr),
		.color      (color),
		.rdata      (rdata),
		.wr         (blend_wr),
		.busy       (blend_busy)
	);

	assign wr = blend_wr.we ? blend_wr : ctrl_wr;

	abf_store u_store (
		.clk   (clk),
		.rd    (rd),
		.wr    (wr),
		.rdata (rdata)
	);

	a_no_wr_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(blend_wr.we && ctrl_wr.we))
		else $error("blend write-back collides with a control write");

	a_no_rw_same_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rd.re && wr.we) |-> (rd.addr != wr.addr))
		else $error("read and write of the same pixel in one cycle");

	a_one_cmd_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("new command taken while one is in flight");

endmodule

@@ design/abf_store.sv @@
module abf_store (
	input  logic                    clk,
	input  abf_pkg::rd_req_t        rd,
	input  abf_pkg::wr_req_t        wr,
	output logic [abf_pkg::PIX_W-1:0] rdata
);
	import abf_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.re) begin
			rdata_q <= mem[rd.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/abf_blend.sv @@
module abf_blend (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      issue,
	input  logic [abf_pkg::AW-1:0]    issue_addr,
	input  abf_pkg::color_t           color,
	input  logic [abf_pkg::PIX_W-1:0] rdata,
	output abf_pkg::wr_req_t          wr,
	output logic                      busy
);
	import abf_pkg::*;

	logic          v_s1, v_s2;
	logic [AW-1:0] addr_s1, addr_s2;
	logic [15:0]   nr_s2, ng_s2, nb_s2;
	logic [7:0]    inv_a;

	function automatic logic [15:0] mix(input logic [7:0] a, input logic [7:0] ia,
		input logic [7:0] c, input logic [7:0] old);
		return 16'(a) * 16'(c) + 16'(ia) * 16'(old);
	endfunction

	// exact floor(n / 255) for n below 65280
	function automatic logic [7:0] div255(input logic [15:0] n);
		logic [16:0] t;
		t = 17'(n) + 17'(n[15:8]) + 17'd1;
		return t[15:8];
	endfunction

	assign inv_a = 8'd255 - color.alpha;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= issue_addr;
		addr_s2 <= addr_s1;
		nr_s2   <= mix(color.alpha, inv_a, color.red,   rdata[23:16]);
		ng_s2   <= mix(color.alpha, inv_a, color.green, rdata[15:8]);
		nb_s2   <= mix(color.alpha, inv_a, color.blue,  rdata[7:0]);
	end

	assign wr.we   = v_s2;
	assign wr.addr = addr_s2;
	assign wr.data = {div255(nr_s2), div255(ng_s2), div255(nb_s2)};
	assign busy    = v_s1 | v_s2;

endmodule

@@ design/abf_ctrl.sv @@
module abf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [abf_pkg::FW-1:0] fw,
	input  logic [abf_pkg::FH-1:0] fh,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  abf_pkg::cmd_t          cmd,
	output logic                   res_valid,
	input  logic                   res_ready,
	output abf_pkg::res_t          res,
	output abf_pkg::rd_req_t       rd,
	output abf_pkg::wr_req_t       wr,
	output logic                   blend_issue,
	output abf_pkg::color_t        color,
	input  logic                   blend_busy,
	input  logic [abf_pkg::PIX_W-1:0] rdata
);
	import abf_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_PIX,
		ST_RDATA,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t        state_q;
	cmd_t          cmd_q;
	res_t          result_q, res_q;
	logic          res_valid_q;
	logic [AW-1:0] clr_cnt_q;
	logic [XW-1:0] col_q, x0_q, xlast_q;
	logic [YW-1:0] row_q, ylast_q;

	logic signed [CW-1:0] ws, hs, xl, yt, xr, yb, x0, y0, x1, y1, xm1, ym1;
	logic                 in_frame, fill_hit;
	logic [AW-1:0]        walk_addr;

	assign ws  = $signed(CW'(fw));
	assign hs  = $signed(CW'(fh));
	assign xl  = CW'(cmd_q.x_left);
	assign yt  = CW'(cmd_q.y_top);
	assign xr  = CW'(cmd_q.x_right);
	assign yb  = CW'(cmd_q.y_bottom);
	assign x0  = (xl < 0) ? '0 : xl;
	assign y0  = (yt < 0) ? '0 : yt;
	assign x1  = (xr > ws) ? ws : xr;
	assign y1  = (yb > hs) ? hs : yb;
	assign xm1 = x1 - CW'(1);
	assign ym1 = y1 - CW'(1);
	assign fill_hit = (x0 < x1) && (y0 < y1);
	assign in_frame = (xl >= 0) && (yt >= 0) && (xl < ws) && (yt < hs);

	assign walk_addr = pix_addr(row_q, col_q, fw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && state_q != ST_DONE) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (cmd_q.op)
						OP_READ, OP_WRITE: begin
							if (in_frame) begin
								result_q <= '0;
								col_q    <= xl[XW-1:0];
								row_q    <= yt[YW-1:0];
								state_q  <= ST_PIX;
							end else begin
								result_q <= '{pixel_data: '0, status: 1'b1};
								state_q  <= ST_DONE;
							end
						end
						OP_FILL: begin
							result_q <= '0;
							if (fill_hit) begin
								col_q   <= x0[XW-1:0];
								x0_q    <= x0[XW-1:0];
								xlast_q <= xm1[XW-1:0];
								row_q   <= y0[YW-1:0];
								ylast_q <= ym1[YW-1:0];
								state_q <= ST_WALK;
							end else begin
								state_q <= ST_DONE;
							end
						end
						default: begin
							result_q <= '0;
							state_q  <= ST_DONE;
						end
					endcase
				end
				ST_PIX: begin
					state_q <= (cmd_q.op == OP_READ) ? ST_RDATA : ST_DONE;
				end
				ST_RDATA: begin
					result_q.pixel_data <= rdata;
					state_q             <= ST_DONE;
				end
				ST_WALK: begin
					if (col_q == xlast_q) begin
						col_q <= x0_q;
						if (row_q == ylast_q) begin
							state_q <= ST_DRAIN;
						end else begin
							row_q <= row_q + YW'(1);
						end
					end else begin
						col_q <= col_q + XW'(1);
					end
				end
				ST_DRAIN: begin
					if (!blend_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || res_ready) begin
						res_q       <= result_q;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
	end

	always_comb begin
		rd.re   = (state_q == ST_WALK) || (state_q == ST_PIX && cmd_q.op == OP_READ);
		rd.addr = walk_addr;
		wr.we   = 1'b0;
		wr.addr = walk_addr;
		wr.data = {cmd_q.red, cmd_q.green, cmd_q.blue};
		if (state_q == ST_CLEAR) begin
			wr.we   = 1'b1;
			wr.addr = clr_cnt_q;
			wr.data = '0;
		end else if (state_q == ST_PIX && cmd_q.op == OP_WRITE) begin
			wr.we = 1'b1;
		end
	end

	assign blend_issue = (state_q == ST_WALK);
	assign color       = '{red: cmd_q.red, green: cmd_q.green, blue: cmd_q.blue,
		alpha: cmd_q.alpha};
	assign cmd_ready   = (state_q == ST_IDLE);
	assign res_valid   = res_valid_q;
	assign res         = res_q;

endmodule

@@ dv/alpha_blend_rect_fill_test.sv @@
module alpha_blend_rect_fill_test;

	import abf_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         STALL_LIMIT = 400000;

	class frame_shadow;
		bit [PIX_W-1:0] pixels [0:DEPTH-1];
		int             width;
		int             height;
		res_t           awaited[$];
		int unsigned    fail_count;

		function new();
			width = FW_RESET;
			height = FH_RESET;
			fail_count = 0;
		endfunction

		function int limit_size(int unsigned v, int max);
			int s;
			s = int'(v & 'h1FF);
			if (s > max) begin
				s = max;
			end
			if (s == 0) begin
				s = 1;
			end
			return s;
		endfunction

		function void resize(int unsigned w, int unsigned h);
			width = limit_size(w, MAX_WIDTH);
			height = limit_size(h, MAX_HEIGHT);
		endfunction

		function bit [7:0] mix(int a, int c, int old);
			return 8'((a * c + (255 - a) * old) / 255);
		endfunction

		function void take_command(cmd_t c);
			int          xl, yt, x0, y0, x1, y1, a;
			int unsigned slot;
			bit [23:0]   old;
			res_t        r;
			xl = $signed(c.x_left);
			yt = $signed(c.y_top);
			a = int'(c.alpha);
			r = '0;
			case (c.op)
				OP_READ, OP_WRITE: begin
					if (xl < 0 || yt < 0 || xl >= width || yt >= height) begin
						r.status = 1'b1;
					end else begin
						slot = yt * width + xl;
						if (c.op == OP_READ) begin
							r.pixel_data = pixels[slot];
						end else begin
							pixels[slot] = {c.red, c.green, c.blue};
						end
					end
				end
				OP_FILL: begin
					x0 = (xl < 0) ? 0 : xl;
					y0 = (yt < 0) ? 0 : yt;
					x1 = ($signed(c.x_right) > width) ? width : $signed(c.x_right);
					y1 = ($signed(c.y_bottom) > height) ? height : $signed(c.y_bottom);
					for (int y = y0; y < y1; y++) begin
						for (int x = x0; x < x1; x++) begin
							slot = y * width + x;
							old = pixels[slot];
							pixels[slot] = {mix(a, c.red, old[23:16]),
								mix(a, c.green, old[15:8]), mix(a, c.blue, old[7:0])};
						end
					end
				end
				default: begin
				end
			endcase
			awaited.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			fail_count++;
		endtask

		task check_result(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result %h with none pending", got));
			end else begin
				want = awaited.pop_front();
				if (got.pixel_data !== want.pixel_data) begin
					report($sformatf("pixel_data %h, want %h", got.pixel_data, want.pixel_data));
				end
				if (got.status !== want.status) begin
					report($sformatf("status %b, want %b", got.status, want.status));
				end
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              cmd_valid;
	logic              cmd_ready;
	cmd_t              cmd;
	logic              res_valid;
	logic              res_ready;
	res_t              res;

	frame_shadow       sb;
	bit                calm;
	int unsigned       quiet_cycles;

	alpha_blend_rect_fill dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #5 clk = ~clk;

	initial begin
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ready <= calm || ($urandom_range(99) >= 33);
		end
	end

	// handshakes are sampled mid-cycle, the transfer happens at the next rising edge
	always @(negedge clk) begin
		if (arst_n === 1'b1) begin
			if (res_valid && res_ready) begin
				sb.check_result(res);
			end
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic cmd_t make_cmd(logic [1:0] op, int xl, int yt, int xr, int yb,
		bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [7:0] a);
		cmd_t c;
		c.op = op_t'(op);
		c.x_left = 16'(xl);
		c.y_top = 16'(yt);
		c.x_right = 16'(xr);
		c.y_bottom = 16'(yb);
		c.red = r;
		c.green = g;
		c.blue = b;
		c.alpha = a;
		return c;
	endfunction

	function automatic int near(int lim);
		return int'($urandom_range(lim + 7)) - 4;
	endfunction

	function automatic cmd_t random_command();
		cmd_t c;
		int   pick, xl, yt;
		pick = $urandom_range(99);
		c.red = 8'($urandom);
		c.green = 8'($urandom);
		c.blue = 8'($urandom);
		case ($urandom_range(9))
			0, 1: c.alpha = 8'd0;
			2, 3: c.alpha = 8'd255;
			default: c.alpha = 8'($urandom);
		endcase
		c.x_right = 16'($urandom);
		c.y_bottom = 16'($urandom);
		if (pick < 45) begin
			c.op = OP_FILL;
			if (sb.width * sb.height <= 4096 && $urandom_range(5) == 0) begin
				c.x_left = 16'($urandom);
				c.y_top = 16'($urandom);
			end else begin
				xl = near(sb.width);
				yt = near(sb.height);
				c.x_left = 16'(xl);
				c.y_top = 16'(yt);
				c.x_right = 16'(xl + int'($urandom_range(24)) - 2);
				c.y_bottom = 16'(yt + int'($urandom_range(24)) - 2);
			end
		end else begin
			if (pick < 70) begin
				c.op = OP_WRITE;
			end else if (pick < 95) begin
				c.op = OP_READ;
			end else begin
				c.op = op_t'(OP_UNUSED);
			end
			if ($urandom_range(99) < 15) begin
				c.x_left = 16'($urandom);
				c.y_top = 16'($urandom);
			end else begin
				c.x_left = 16'(near(sb.width));
				c.y_top = 16'(near(sb.height));
			end
		end
		return c;
	endfunction

	task automatic issue_command(cmd_t c);
		while (!calm && $urandom_range(99) < 33) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(negedge clk);
		while (!cmd_ready) begin
			@(negedge clk);
		end
		sb.take_command(c);
		@(posedge clk);
	endtask

	task automatic hold_until_drained();
		cmd_valid <= 1'b0;
		while (sb.awaited.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_frame_size(int unsigned w, int unsigned h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.resize(w, h);
		@(posedge clk);
	endtask

	initial begin
		int unsigned sizes [6][2];
		sb = new();
		calm = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		cmd_valid = 1'b0;
		cmd = '0;
		sizes = '{'{0, 511}, '{511, 0}, '{1, 1}, '{37, 200}, '{256, 256}, '{100, 13}};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// frame at its reset size, 256 x 256
		issue_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		issue_command(make_cmd(OP_WRITE, 255, 255, -32768, 32767, 255, 255, 255, 255));
		issue_command(make_cmd(OP_READ, 255, 255, 32767, -32768, 0, 0, 0, 0));
		issue_command(make_cmd(OP_WRITE, 0, 0, 0, 0, 8'h12, 8'h34, 8'h56, 0));
		issue_command(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		issue_command(make_cmd(OP_READ, -1, 0, 0, 0, 0, 0, 0, 0));
		issue_command(make_cmd(OP_READ, 0, -32768, 0, 0, 0, 0, 0, 0));
		issue_command(make_cmd(OP_WRITE, 256, 0, 0, 0, 1, 2, 3, 0));
		issue_command(make_cmd(OP_WRITE, 32767, 32767, 0, 0, 1, 2, 3, 0));
		issue_command(make_cmd(OP_READ, 0, 256, 0, 0, 0, 0, 0, 0));
		issue_command(make_cmd(OP_FILL, -32768, -32768, 32767, 32767, 8'h80, 8'h40, 8'h20, 255));
		issue_command(make_cmd(OP_READ, 255, 255, 0, 0, 0, 0, 0, 0));
		issue_command(make_cmd(OP_FILL, 2, 2, 10, 10, 255, 255, 255, 0));
		issue_command(make_cmd(OP_FILL, 20, 5, 10, 9, 255, 0, 0, 255));
		issue_command(make_cmd(OP_FILL, 7, 7, 7, 12, 0, 255, 0, 255));
		issue_command(make_cmd(OP_FILL, 300, 0, 400, 10, 0, 0, 255, 255));
		issue_command(make_cmd(OP_FILL, -20, -20, -5, -5, 0, 0, 255, 255));
		issue_command(make_cmd(OP_FILL, -3, -3, 5, 5, 255, 0, 255, 128));
		issue_command(make_cmd(OP_READ, 2, 2, 0, 0, 0, 0, 0, 0));
		issue_command(make_cmd(OP_READ, 4, 4, 0, 0, 0, 0, 0, 0));
		issue_command(make_cmd(OP_READ, 5, 5, 0, 0, 0, 0, 0, 0));
		issue_command(make_cmd(OP_UNUSED, 3, 3, 0, 0, 255, 255, 255, 255));
		issue_command(make_cmd(OP_FILL, 255, 0, 256, 1, 8'h11, 8'hEE, 8'h77, 200));
		issue_command(make_cmd(OP_READ, 255, 0, 0, 0, 0, 0, 0, 0));

		for (int i = 0; i < 30; i++) begin
			if (i == 15) begin
				hold_until_drained();
			end
			issue_command(random_command());
		end

		foreach (sizes[p]) begin
			hold_until_drained();
			write_frame_size(sizes[p][0], sizes[p][1]);
			calm = (p == 3);
			for (int i = 0; i < 15; i++) begin
				issue_command(random_command());
			end
		end
		calm = 1'b0;

		hold_until_drained();
		repeat (16) @(posedge clk);
		if (sb.fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
